@@ rtl/maze_backtracker_generator_top_macros.svh @@
// Assertion macros shared by the maze generator checker
`ifndef MAZE_BACKTRACKER_GENERATOR_TOP_MACROS_SVH
`define MAZE_BACKTRACKER_GENERATOR_TOP_MACROS_SVH
// Assert an implication on the clock, disabled in reset
`define MBG_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Assert an implication checked in the next cycle
`define MBG_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/mbg_pkg.sv @@
// Package: shared types and constants of the maze generator
`default_nettype none
package mbg_pkg;
    localparam int MAX_SIZE = 64;
    localparam logic [1:0] CELL_OPEN = 2'd0;
    localparam logic [1:0] CELL_WORK = 2'd1;
    localparam logic [1:0] CELL_WALL = 2'd2;
    localparam logic [1:0] CELL_SEEN = 2'd3;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic CMD_GEN = 1'b0;
    localparam logic CMD_READ = 1'b1;
    localparam logic REG_SIZE = 1'b0;
    localparam logic REG_SEED = 1'b1;
    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    typedef struct packed {
        logic       cmd;
        logic [5:0] row;
        logic [5:0] col;
        logic       out_rng;
    } mbg_job_t;

    typedef enum logic [4:0] {
        B_IDLE, B_INIT, B_POP, B_POPW, B_N0, B_N1, B_N2, B_N3, B_NW, B_DEC,
        B_PUSH1, B_WALL, B_SEEN, B_PUSH2, B_FIN_RD, B_FIN_WR, B_RD, B_RDW, B_DONE
    } mbg_state_t;
endpackage
`default_nettype wire

@@ rtl/mbg_ram.sv @@
// Generic single-port-write, single-read RAM with registered read
`default_nettype none
module mbg_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/mbg_front.sv @@
// Front end: accept commands, classify reads against the grid, queue them
`default_nettype none
module mbg_front (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  wire [15:0]        s_tdata,
    input  wire [6:0]         eff_size,
    output logic              q_valid,
    input  wire               q_pop,
    output mbg_pkg::mbg_job_t q_job
);
    import mbg_pkg::*;
    mbg_job_t q_reg [2];
    logic     wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    mbg_job_t in_job;
    logic push;

    always_comb begin
        in_job.cmd = s_tdata[0];
        in_job.row = s_tdata[6:1];
        in_job.col = s_tdata[12:7];
        in_job.out_rng = ({1'b0, s_tdata[6:1]} >= eff_size) ||
                         ({1'b0, s_tdata[12:7]} >= eff_size);
    end
    assign s_tready = (cnt_reg != 2'd2);
    assign push = s_tvalid && s_tready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_job = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) q_reg[wp_reg] <= in_job;
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule
`default_nettype wire

@@ rtl/mbg_back.sv @@
// Back end: maze walk, final grid conversion, cell reads
`default_nettype none
module mbg_back #(
    parameter int STACK_DEPTH = 1024
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               q_valid,
    output logic              q_pop,
    input  mbg_pkg::mbg_job_t q_job,
    input  wire [6:0]         eff_size,
    input  wire [31:0]        seed,
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [1:0]        m_status,
    output logic [1:0]        m_value
);
    import mbg_pkg::*;
    localparam int CW = $clog2(MAX_SIZE);
    localparam int AW = 2 * CW;
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int PW = SW + 1;
    localparam int NCELL = MAX_SIZE * MAX_SIZE;

    mbg_state_t st_reg, st_next;
    logic [AW:0]    sweep_reg, sweep_next;
    logic           epoch_reg, epoch_next;   // grid valid since reset
    logic [PW-1:0]  sp_reg, sp_next;
    logic [31:0]    lfsr_reg, lfsr_next;
    logic [CW-1:0]  r_reg, r_next, c_reg, c_next;
    logic [3:0]     nmask_reg, nmask_next;
    logic [1:0]     ndir_reg [4];
    logic [2:0]     ncnt_reg, ncnt_next;
    logic [1:0]     pick_reg, pick_next;
    logic           ok_reg, ok_next;
    logic           ovf_reg, ovf_next;
    logic [1:0]     ostat_reg, ostat_next, oval_reg, oval_next;
    logic           ov_reg, ov_next;

    logic           g_we;
    logic [AW-1:0]  g_wa, g_ra;
    logic [1:0]     g_wd, g_rd;
    logic           s_we;
    logic [SW-1:0]  s_wa, s_ra;
    logic [AW-1:0]  s_wd, s_rd;

    mbg_ram #(.WIDTH(2), .DEPTH(NCELL)) u_grid (
        .aclk(aclk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
    mbg_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk(aclk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

    // remainder by three: base-4 digit sum, folded as an adder tree
    function automatic logic [1:0] mod3(input logic [31:0] v);
        logic [2:0] p [8];
        logic [3:0] q [4];
        logic [5:0] s;
        logic [3:0] t;
        for (int i = 0; i < 8; i++) p[i] = 3'(v[4*i +: 2]) + 3'(v[4*i+2 +: 2]);
        for (int i = 0; i < 4; i++) q[i] = 4'(p[2*i]) + 4'(p[2*i+1]);
        s = 6'(q[0]) + 6'(q[1]) + 6'(q[2]) + 6'(q[3]);
        t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
        if (t >= 4'd6) t = t - 4'd6;
        else if (t >= 4'd3) t = t - 4'd3;
        return t[1:0];
    endfunction

    // neighbour coordinates for direction d
    logic [CW+1:0] tr [4], tc [4];
    logic          tin [4];
    always_comb begin
        for (int d = 0; d < 4; d++) begin
            tr[d] = {2'b0, r_reg};
            tc[d] = {2'b0, c_reg};
        end
        tr[0] = {2'b0, r_reg} + (CW+2)'(2);
        tc[1] = {2'b0, c_reg} + (CW+2)'(2);
        tr[2] = {2'b0, r_reg} - (CW+2)'(2);
        tc[3] = {2'b0, c_reg} - (CW+2)'(2);
        for (int d = 0; d < 4; d++)
            tin[d] = !tr[d][CW+1] && !tc[d][CW+1] &&
                     (tr[d] < (CW+2)'(eff_size)) && (tc[d] < (CW+2)'(eff_size));
    end

    logic [1:0] ndir_sel;
    logic [CW-1:0] nr, nc, wr, wc;
    logic [2:0] kmod;
    logic [31:0] lfsr_step;
    logic [1:0] init_val;
    logic [CW-1:0] sr, sc;
    logic [CW+1:0] eff_ext;
    always_comb begin
        ndir_sel = ndir_reg[pick_reg];
        nr = tr[ndir_sel][CW-1:0];
        nc = tc[ndir_sel][CW-1:0];
        wr = CW'(({1'b0, nr} + {1'b0, r_reg}) >> 1);
        wc = CW'(({1'b0, nc} + {1'b0, c_reg}) >> 1);
        // the pick uses the value after this choice's step
        lfsr_step = {1'b0, lfsr_reg[31:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : 32'd0);
        unique case (ncnt_reg)
            3'd1: kmod = 3'd0;
            3'd2: kmod = {2'b0, lfsr_step[0]};
            3'd3: kmod = {1'b0, mod3(lfsr_step)};
            default: kmod = {1'b0, lfsr_step[1:0]};
        endcase
        sr = sweep_reg[AW-1:CW];
        sc = sweep_reg[CW-1:0];
        eff_ext = (CW+2)'(eff_size);
        init_val = ((CW+2)'(sr) < eff_ext && (CW+2)'(sc) < eff_ext && sr[0] && sc[0]) ?
                   CELL_OPEN : CELL_WORK;
    end

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            B_IDLE: if (q_valid && !ov_reg) st_next = (q_job.cmd == CMD_GEN) ? B_INIT : B_RD;
            B_INIT: if (sweep_reg == (AW+1)'(NCELL - 1)) st_next = B_POP;
            B_POP: st_next = (ok_reg && sp_reg != '0) ? B_POPW : B_FIN_RD;
            B_POPW: st_next = B_N0;
            B_N0: st_next = B_N1;
            B_N1: st_next = B_N2;
            B_N2: st_next = B_N3;
            B_N3: st_next = B_NW;
            B_NW: st_next = B_DEC;
            B_DEC: st_next = (ncnt_reg == 3'd0) ? B_POP : B_PUSH1;
            B_PUSH1: st_next = (sp_reg >= PW'(STACK_DEPTH)) ? B_FIN_RD : B_WALL;
            B_WALL: st_next = B_SEEN;
            B_SEEN: st_next = B_PUSH2;
            B_PUSH2: st_next = B_POP;
            B_FIN_RD: st_next = B_FIN_WR;
            B_FIN_WR: st_next = (sweep_reg == (AW+1)'(NCELL - 1)) ? B_DONE : B_FIN_RD;
            B_RD: st_next = B_RDW;
            B_RDW: st_next = B_DONE;
            B_DONE: st_next = B_IDLE;
            default: st_next = B_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        sweep_next = sweep_reg; epoch_next = epoch_reg; sp_next = sp_reg;
        lfsr_next = lfsr_reg; r_next = r_reg; c_next = c_reg;
        nmask_next = nmask_reg; ncnt_next = ncnt_reg; pick_next = pick_reg;
        ok_next = ok_reg; ovf_next = ovf_reg; ostat_next = ostat_reg;
        oval_next = oval_reg; ov_next = ov_reg;
        q_pop = 1'b0;
        g_we = 1'b0; g_wa = sweep_reg[AW-1:0]; g_wd = init_val;
        g_ra = sweep_reg[AW-1:0];
        s_we = 1'b0; s_wa = sp_reg[SW-1:0]; s_wd = {r_reg, c_reg};
        s_ra = SW'(sp_reg - PW'(1));
        if (ov_reg && m_tready) ov_next = 1'b0;
        unique case (st_reg)
            B_IDLE: begin
                sweep_next = '0;
                lfsr_next = (seed == 32'd0) ? 32'd1 : seed;
                ok_next = 1'b1; ovf_next = 1'b0;
            end
            B_INIT: begin
                g_we = 1'b1;
                if ((AW)'(sweep_reg) == AW'(MAX_SIZE + 1)) g_wd = CELL_SEEN;
                sweep_next = sweep_reg + 1'b1;
                // seed stack with (1,1)
                s_we = 1'b1; s_wa = '0; s_wd = {CW'(1), CW'(1)};
                sp_next = PW'(1);
            end
            B_POP: begin
                sweep_next = '0;
                if (ok_reg && sp_reg != '0) sp_next = sp_reg - 1'b1;
            end
            // hold the read on the popped entry
            B_POPW: s_ra = sp_reg[SW-1:0];
            B_N0: begin
                r_next = s_rd[AW-1:CW]; c_next = s_rd[CW-1:0];
                ncnt_next = '0; nmask_next = '0;
            end
            B_N1, B_N2, B_N3, B_NW: begin
                // issue read of direction k, compare it in the state that follows
            end
            B_DEC: begin
                pick_next = kmod[1:0];
                if (ncnt_reg != 3'd0) begin
                    ;
                end
            end
            B_PUSH1: begin
                if (sp_reg >= PW'(STACK_DEPTH)) begin
                    ok_next = 1'b0; ovf_next = 1'b1;
                end else begin
                    s_we = 1'b1; sp_next = sp_reg + 1'b1;
                end
            end
            B_WALL: begin
                g_we = 1'b1; g_wa = {wr, wc}; g_wd = CELL_OPEN;
            end
            B_SEEN: begin
                g_we = 1'b1; g_wa = {nr, nc}; g_wd = CELL_SEEN;
            end
            B_PUSH2: begin
                if (sp_reg >= PW'(STACK_DEPTH)) begin
                    ok_next = 1'b0; ovf_next = 1'b1;
                end else begin
                    s_we = 1'b1; s_wd = {nr, nc}; sp_next = sp_reg + 1'b1;
                end
            end
            B_FIN_RD: g_ra = sweep_reg[AW-1:0];
            B_FIN_WR: begin
                g_we = 1'b1;
                g_wd = (g_rd == CELL_SEEN || g_rd == CELL_OPEN) ? CELL_OPEN : CELL_WALL;
                sweep_next = sweep_reg + 1'b1;
                epoch_next = 1'b1;
            end
            B_RD, B_RDW: g_ra = {q_job.row[CW-1:0], q_job.col[CW-1:0]};
            B_DONE: begin
                q_pop = 1'b1; ov_next = 1'b1; sp_next = '0;
                if (q_job.cmd == CMD_GEN) begin
                    ostat_next = ovf_reg ? ST_OVF : ST_OK; oval_next = CELL_OPEN;
                end else if (q_job.out_rng) begin
                    ostat_next = ST_RANGE; oval_next = CELL_OPEN;
                end else begin
                    ostat_next = ST_OK; oval_next = epoch_reg ? g_rd : CELL_WALL;
                end
            end
            default: ;
        endcase
        // neighbour scan: read issued in N0..N3, checked in the next cycle
        if (st_reg == B_N0 || st_reg == B_N1 || st_reg == B_N2 || st_reg == B_N3) begin
            if (st_reg == B_N0) g_ra = {s_rd[AW-1:CW] + CW'(2), s_rd[CW-1:0]};
            else g_ra = {tr[2'(st_reg - B_N0)][CW-1:0], tc[2'(st_reg - B_N0)][CW-1:0]};
        end
        if (st_reg == B_N1 || st_reg == B_N2 || st_reg == B_N3 || st_reg == B_NW) begin
            if (tin[2'(st_reg - B_N1)] && g_rd != CELL_SEEN) begin
                ncnt_next = ncnt_reg + 3'd1;
                nmask_next[2'(st_reg - B_N1)] = 1'b1;
            end
        end
        if (st_reg == B_DEC && ncnt_reg != 3'd0) begin
            lfsr_next = lfsr_step;
        end
    end

    // pack the open directions in scan order
    logic [1:0] nd [4];
    always_comb begin
        logic [1:0] k;
        k = 2'd0;
        for (int d = 0; d < 4; d++) nd[d] = 2'd0;
        for (int d = 0; d < 4; d++) if (nmask_reg[d]) begin
            nd[k] = 2'(d); k = k + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        for (int d = 0; d < 4; d++) ndir_reg[d] <= nd[d];
        sweep_reg <= sweep_next; r_reg <= r_next; c_reg <= c_next;
        nmask_reg <= nmask_next; ncnt_reg <= ncnt_next; pick_reg <= pick_next;
        ostat_reg <= ostat_next; oval_reg <= oval_next;
        ok_reg <= ok_next; ovf_reg <= ovf_next;
        if (!aresetn) begin
            st_reg <= B_IDLE; ov_reg <= 1'b0; epoch_reg <= 1'b0;
            lfsr_reg <= 32'd1; sp_reg <= '0;
        end else begin
            st_reg <= st_next; ov_reg <= ov_next; epoch_reg <= epoch_next;
            lfsr_reg <= lfsr_next; sp_reg <= sp_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_status = ostat_reg;
    assign m_value = oval_reg;
endmodule
`default_nettype wire

@@ rtl/maze_backtracker_generator_top.sv @@
// Top level: maze generator with command front end and walk back end
//  channel | direction | contents
//  s_      | in        | tdata[0] cmd, [6:1] row, [12:7] col
//  m_      | out       | tdata[1:0] status, [3:2] cell_value
//  cfg_    | in        | cfg_index 0 grid_size, 1 random_seed
// A read passes the front queue and states IDLE, RD, RDW, DONE before its result is registered.
// A generate writes each grid cell once in INIT, converts the grid with a read and a write
// state per cell, and walks popped cells through POP..DEC, plus PUSH1..PUSH2 for a carved wall.
// Reset is synchronous; the grid reads as wall until the first generate.
// Up to two commands queue while the back end works or the result stalls.
`default_nettype none
module maze_backtracker_generator_top #(
    parameter int STACK_DEPTH = 1024
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [15:0] s_tdata,   // cmd, row, col
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // status, cell_value
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire        cfg_index,
    input  wire [31:0] cfg_data
);
    import mbg_pkg::*;
    logic [6:0]  size_reg;
    logic [31:0] seed_reg;
    logic [6:0]  eff_size;
    logic        q_valid, q_pop;
    mbg_job_t    q_job;
    logic [1:0]  st, val;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= 7'd63; seed_reg <= 32'd1;
        end else if (cfg_valid) begin
            if (cfg_index == REG_SIZE) size_reg <= cfg_data[6:0];
            else seed_reg <= cfg_data;
        end
    end
    // clamp size to the supported range
    assign eff_size = (size_reg < 7'd3) ? 7'd3 :
                      ({25'b0, size_reg} > MAX_SIZE) ? 7'(MAX_SIZE) : size_reg;

    mbg_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .eff_size(eff_size), .q_valid(q_valid), .q_pop(q_pop),
        .q_job(q_job));
    mbg_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_pop(q_pop),
        .q_job(q_job), .eff_size(eff_size), .seed(seed_reg), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_status(st), .m_value(val));
    assign m_tdata = {4'b0, val, st};
endmodule
`default_nettype wire

@@ rtl/mbg_checker.sv @@
// Port checker for the maze generator top level
`default_nettype none
`include "maze_backtracker_generator_top_macros.svh"
module mbg_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata,
    input wire       cfg_ready
);
    `MBG_ASSERT_IMP(a_stat, aclk, aresetn, m_tvalid, m_tdata[1:0] != 2'd3, "bad status")
    `MBG_ASSERT_IMP(a_zero, aclk, aresetn, m_tvalid && m_tdata[1:0] != 2'd0, m_tdata[3:2] == 2'd0, "value with error")
    `MBG_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stall dropped")
    `MBG_ASSERT_IMP(a_cfg, aclk, aresetn, 1'b1, cfg_ready, "cfg not ready")
endmodule
bind maze_backtracker_generator_top mbg_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .cfg_ready(cfg_ready));
`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for the maze generator: directed and random commands checked against a local maze model
`default_nettype none
module tb_top;
    import mbg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_W    = 64;
    localparam int TRAIL_MAX = 1024;
    localparam int IDLE_LIMIT = 200000;   // outlasts a full 64x64 generate, which makes no transfer
    localparam int SETTLE    = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    wire         s_tready;
    logic [15:0] s_tdata;
    wire         m_tvalid;
    logic        m_tready;
    wire  [7:0]  m_tdata;
    logic        cfg_valid;
    wire         cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    maze_backtracker_generator_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock: 10 ns period
    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    // Model state: grid contents, walk stack and the two registers
    logic [1:0]  maze_cells [GRID_W*GRID_W];
    int          walk_trail [TRAIL_MAX];
    logic [6:0]  side_reg;
    logic [31:0] seed_reg;

    // Commands waiting to be driven, packed as {col,row,cmd}
    logic [12:0] cmd_backlog[$];
    // Outstanding results, packed as {cell_value,status}
    logic [3:0]  due_results[$];

    int pace_mode;   // 0 none, 1 sender idles, 2 receiver stalls, 3 both
    int errors, n_gen, n_read, n_range, n_results;
    int quiet_cycles;

    function automatic bit hold_off(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int eff_side();
        if (side_reg < 3) return 3;
        if (side_reg > GRID_W) return GRID_W;
        return int'(side_reg);
    endfunction

    // Rebuild the maze by depth-first backtracking; returns the status code
    function automatic logic [1:0] carve_maze();
        int dr[4] = '{2, 0, -2, 0};
        int dc[4] = '{0, 2, 0, -2};
        int nr[4], nc[4];
        int sz, r, c, i, cnt, k, sp, tr, tc;
        bit ok, lsb;
        logic [31:0] lfsr;
        sz = eff_side();
        for (r = 0; r < GRID_W; r++)
            for (c = 0; c < GRID_W; c++)
                maze_cells[r*GRID_W+c] = (r < sz && c < sz && r[0] && c[0]) ? CELL_OPEN
                                                                          : CELL_WORK;
        lfsr = (seed_reg != 0) ? seed_reg : 32'd1;
        maze_cells[GRID_W+1] = CELL_SEEN;
        walk_trail[0] = (1 << 16) | 1;
        sp = 1;
        ok = 1'b1;
        while (ok && sp > 0) begin
            sp--;
            r = walk_trail[sp] >> 16;
            c = walk_trail[sp] & 16'hFFFF;
            cnt = 0;
            for (i = 0; i < 4; i++) begin
                tr = r + dr[i];
                tc = c + dc[i];
                if (tr >= 0 && tr < sz && tc >= 0 && tc < sz &&
                    maze_cells[tr*GRID_W+tc] != CELL_SEEN) begin
                    nr[cnt] = tr;
                    nc[cnt] = tc;
                    cnt++;
                end
            end
            if (cnt > 0) begin
                if (sp >= TRAIL_MAX) begin
                    ok = 1'b0;
                    break;
                end
                walk_trail[sp] = (r << 16) | c;
                sp++;
                lsb  = lfsr[0];
                lfsr = lfsr >> 1;
                if (lsb) lfsr = lfsr ^ LFSR_TAPS;
                k = int'(lfsr % cnt);
                maze_cells[((nr[k]+r) >> 1)*GRID_W + ((nc[k]+c) >> 1)] = CELL_OPEN;
                maze_cells[nr[k]*GRID_W + nc[k]] = CELL_SEEN;
                if (sp >= TRAIL_MAX) begin
                    ok = 1'b0;
                    break;
                end
                walk_trail[sp] = (nr[k] << 16) | nc[k];
                sp++;
            end
        end
        for (i = 0; i < GRID_W*GRID_W; i++) begin
            if (maze_cells[i] == CELL_SEEN) maze_cells[i] = CELL_OPEN;
            else if (maze_cells[i] == CELL_WORK) maze_cells[i] = CELL_WALL;
        end
        return ok ? ST_OK : ST_OVF;
    endfunction

    // Work out the result of one accepted command and queue it
    task automatic forecast_result(input logic [12:0] item);
        logic [5:0] row, col;
        int sz;
        row = item[6:1];
        col = item[12:7];
        if (item[0] == CMD_GEN) begin
            n_gen++;
            due_results.push_back({2'b00, carve_maze()});
        end else begin
            n_read++;
            sz = eff_side();
            if (row >= sz || col >= sz) begin
                n_range++;
                due_results.push_back({2'b00, ST_RANGE});
            end else begin
                due_results.push_back({maze_cells[row*GRID_W+col], ST_OK});
            end
        end
    endtask

    // Driver: predict on each input transfer, then present the next command
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) forecast_result(s_tdata[12:0]);
            if (!s_tvalid || s_tready) begin
                if (cmd_backlog.size() > 0 &&
                    !hold_off(pace_mode == 1 ? 49 : pace_mode == 3 ? 25 : 0)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, cmd_backlog.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (due_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result status=%0d cell=%0d",
                             $realtime, m_tdata[1:0], m_tdata[3:2]);
                end else begin
                    if (m_tdata[1:0] !== due_results[0][1:0]) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, due_results[0][1:0], m_tdata[1:0]);
                    end
                    if (m_tdata[3:2] !== due_results[0][3:2]) begin
                        errors++;
                        $display("%0t: cell_value expected %0d actual %0d",
                                 $realtime, due_results[0][3:2], m_tdata[3:2]);
                    end
                    void'(due_results.pop_front());
                end
            end
            m_tready <= !hold_off(pace_mode == 2 ? 49 : pace_mode == 3 ? 25 : 0);
        end
    end

    // Watchdog: count cycles in which no transfer of any kind happens
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Write one register; hold valid until the transfer completes
    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_SIZE) side_reg = value[6:0];
        else seed_reg = value;
        cfg_valid <= 1'b0;
    endtask

    // Hold until every command is sent and every result is back, then let the block settle
    task automatic drain();
        while (cmd_backlog.size() > 0 || s_tvalid || due_results.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic queue_cmd(input logic cmd, input int row, input int col);
        cmd_backlog.push_back({col[5:0], row[5:0], cmd});
    endtask

    // Random commands: mostly reads, in and out of the grid, with an occasional rebuild
    task automatic queue_random(input int count, input bit allow_gen);
        int i, sz;
        sz = eff_side();
        for (i = 0; i < count; i++) begin
            if (allow_gen && $urandom_range(99) < 8)
                queue_cmd(CMD_GEN, $urandom_range(63), $urandom_range(63));
            else if ($urandom_range(1))
                queue_cmd(CMD_READ, $urandom_range(sz-1), $urandom_range(sz-1));
            else
                queue_cmd(CMD_READ, $urandom_range(63), $urandom_range(63));
        end
    endtask

    initial begin
        int p;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        pace_mode = 0;
        errors = 0; n_gen = 0; n_read = 0; n_range = 0; n_results = 0;
        side_reg = 7'd63;
        seed_reg = 32'd1;
        foreach (maze_cells[i]) maze_cells[i] = CELL_WALL;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reads before any rebuild see walls, then default size and seed
        queue_cmd(CMD_READ, 0, 0);
        queue_cmd(CMD_READ, 63, 63);
        queue_cmd(CMD_READ, 1, 1);
        queue_cmd(CMD_GEN, 63, 63);
        queue_cmd(CMD_READ, 1, 1);
        queue_cmd(CMD_READ, 0, 0);
        queue_cmd(CMD_READ, 62, 62);
        queue_cmd(CMD_READ, 1, 2);
        queue_cmd(CMD_READ, 63, 0);
        queue_cmd(CMD_READ, 0, 63);
        drain();

        // Smallest grid, zero seed falls back to one
        write_reg(REG_SIZE, 32'd3);
        write_reg(REG_SEED, 32'd0);
        queue_cmd(CMD_GEN, 0, 0);
        queue_cmd(CMD_READ, 1, 1);
        queue_cmd(CMD_READ, 2, 2);
        queue_cmd(CMD_READ, 3, 0);
        drain();

        // Grow the size without rebuilding: storage outside the old square reads wall
        write_reg(REG_SIZE, 32'd64);
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        queue_cmd(CMD_READ, 5, 5);
        queue_cmd(CMD_READ, 63, 63);
        queue_cmd(CMD_GEN, 42, 21);
        queue_cmd(CMD_READ, 63, 63);
        queue_cmd(CMD_READ, 61, 62);
        drain();

        // Sizes beyond the legal range clamp to the extremes
        write_reg(REG_SIZE, 32'd0);
        queue_cmd(CMD_GEN, 0, 0);
        queue_cmd(CMD_READ, 2, 1);
        drain();
        write_reg(REG_SIZE, 32'h7F);
        queue_cmd(CMD_READ, 63, 63);
        queue_cmd(CMD_READ, 62, 63);
        drain();

        // Random phases: rotate the pacing, mostly small grids, a few full-sized ones
        for (p = 0; p < 8; p++) begin
            pace_mode = p % 4;
            write_reg(REG_SIZE, (p % 4 == 3) ? 32'd64 : $urandom_range(15, 3));
            write_reg(REG_SEED, $urandom() | 32'd1);
            queue_cmd(CMD_GEN, $urandom_range(63), $urandom_range(63));
            queue_random(9, p % 4 != 3);
            drain();
        end

        repeat (SETTLE) @(posedge aclk);
        errors += due_results.size();
        $display("Covered %0d rebuilds and %0d reads (%0d outside the grid), %0d results",
                 n_gen, n_read, n_range, n_results);
        $display("under four pacing modes with grid sizes from 3 to 64.");
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/mbg_pkg.sv
rtl/mbg_ram.sv
rtl/mbg_front.sv
rtl/mbg_back.sv
rtl/maze_backtracker_generator_top.sv
rtl/mbg_checker.sv
sim/tb_top.sv
